>>> rtl/dsd_pkg.sv
// Shared types, state codes and statusword masks for the drive status decoder.
package dsd_pkg;

    // Default log ring depth
    localparam int LOG_DEPTH_DEF = 16;

    // Field widths
    localparam int STATE_W = 4;
    localparam int SW_W    = 16;
    localparam int TIME_W  = 32;
    localparam int IDX_W   = 4;
    localparam int COUNT_W = 5;
    localparam int SLOT_W  = 4;
    localparam int ENTRY_W = TIME_W + 2 * STATE_W + SW_W;

    // Stream data widths, padded to whole bytes
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 80;

    // Drive state codes
    localparam logic [STATE_W-1:0] ST_NOT_READY     = 4'd0;
    localparam logic [STATE_W-1:0] ST_SW_ON_DISABLE = 4'd1;
    localparam logic [STATE_W-1:0] ST_READY         = 4'd2;
    localparam logic [STATE_W-1:0] ST_SWITCHED_ON   = 4'd3;
    localparam logic [STATE_W-1:0] ST_OP_ENABLED    = 4'd4;
    localparam logic [STATE_W-1:0] ST_QUICK_STOP    = 4'd5;
    localparam logic [STATE_W-1:0] ST_FAULT_REACT   = 4'd6;
    localparam logic [STATE_W-1:0] ST_FAULT         = 4'd7;
    localparam logic [STATE_W-1:0] ST_UNKNOWN       = 4'd8;

    // Statusword masks and patterns
    localparam logic [SW_W-1:0] SW_STATE_MASK = 16'h006F;
    localparam logic [SW_W-1:0] SW_MASK_SHORT = 16'h004F;
    localparam logic [SW_W-1:0] SW_PAT_NRDY   = 16'h0000;
    localparam logic [SW_W-1:0] SW_PAT_SOD    = 16'h0040;
    localparam logic [SW_W-1:0] SW_PAT_RDY    = 16'h0021;
    localparam logic [SW_W-1:0] SW_PAT_SWON   = 16'h0023;
    localparam logic [SW_W-1:0] SW_PAT_OPEN   = 16'h0027;
    localparam logic [SW_W-1:0] SW_PAT_QSTOP  = 16'h0007;
    localparam logic [SW_W-1:0] SW_PAT_FREACT = 16'h000F;
    localparam logic [SW_W-1:0] SW_PAT_FAULT  = 16'h0008;

    // Statusword bit positions of the flags
    localparam int SW_BIT_TARGET  = 10;
    localparam int SW_BIT_FAULT   = 3;
    localparam int SW_BIT_WARNING = 7;

    // Decoded statusword: flags bit0 target reached, bit1 fault, bit2 warning
    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [2:0]         flags;
    } dsd_status_t;

    // Source of the entry fields in a result
    typedef enum logic [1:0] {
        ENTRY_ZERO,
        ENTRY_RAM,
        ENTRY_BYPASS
    } entry_src_t;

endpackage

>>> rtl/dsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port, old data on a same-address write
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/dsd_decode.sv
// Statusword decode into drive state code and flag bits.
module dsd_decode import dsd_pkg::*; (
    input  logic [SW_W-1:0] status_word,
    output dsd_status_t     status
);

    logic [SW_W-1:0] masked;
    logic [SW_W-1:0] short_m;

    assign masked  = status_word & SW_STATE_MASK;
    assign short_m = masked & SW_MASK_SHORT;

    // Pick out target reached, fault and warning; check patterns in priority order
    always_comb begin
        status.flags = {status_word[SW_BIT_WARNING], status_word[SW_BIT_FAULT],
                        status_word[SW_BIT_TARGET]};
        if (short_m == SW_PAT_NRDY) begin
            status.state = ST_NOT_READY;
        end else if (short_m == SW_PAT_SOD) begin
            status.state = ST_SW_ON_DISABLE;
        end else if (masked == SW_PAT_RDY) begin
            status.state = ST_READY;
        end else if (masked == SW_PAT_SWON) begin
            status.state = ST_SWITCHED_ON;
        end else if (masked == SW_PAT_OPEN) begin
            status.state = ST_OP_ENABLED;
        end else if (masked == SW_PAT_QSTOP) begin
            status.state = ST_QUICK_STOP;
        end else if (short_m == SW_PAT_FREACT) begin
            status.state = ST_FAULT_REACT;
        end else if (short_m == SW_PAT_FAULT) begin
            status.state = ST_FAULT;
        end else begin
            status.state = ST_UNKNOWN;
        end
    end

endmodule

>>> rtl/drive_status_decode_and_log.sv
// Top level: drive status decode, last-state tracking and transition log.
//
// Takes one item per cycle when the result side does not stall and returns one
// result per item. An item is held in an input register, where its statusword
// is decoded and compared with the last state; when the result register has
// room, a changed state is written into the log RAM, the requested slot is
// read from the same RAM into its registered read port, and the rest lands in
// the result register. The single write and single registered read of the log
// RAM per cycle set that rate. A per-slot valid bit makes never-written slots
// read as zero right after reset, so no clearing pass is needed. Update items
// are ignored while monitor_enable is clear; they still return a result.
module drive_status_decode_and_log import dsd_pkg::*; #(
    parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration: monitor_enable
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    // Input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // s_tdata: status_word[15:0], time_now[47:16], log_index[51:48], zero[55:52]
    input  logic [S_DATA_W-1:0] s_tdata,
    // s_tuser: req_type[0]
    input  logic                s_tuser,
    // Result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // m_tdata: state_code[3:0], target_reached[4], fault_flag[5], warning_flag[6],
    //          changed[7], entry_time[39:8], entry_from[43:40], entry_to[47:44],
    //          entry_status[63:48], entry_count[68:64], write_slot[72:69], zero[79:73]
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(LOG_DEPTH);
    localparam int CW = $clog2(LOG_DEPTH + 1);
    localparam int NSLOT = 2 ** AW;

    // Control registers
    logic             enable_reg;
    logic             s0_valid_reg;
    logic             m_valid_reg;
    logic [STATE_W-1:0] last_state_reg, last_state_next;
    logic [2:0]       last_flags_reg, last_flags_next;
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [NSLOT-1:0] slot_valid_reg;

    // Input stage payload
    logic             s0_req_reg;
    logic [SW_W-1:0]  s0_sw_reg;
    logic [TIME_W-1:0] s0_time_reg;
    logic [IDX_W-1:0] s0_idx_reg;

    // Result stage payload
    logic [STATE_W-1:0] m_state_reg;
    logic [2:0]       m_flags_reg;
    logic             m_changed_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [SLOT_W-1:0] m_slot_reg;
    entry_src_t       m_src_reg, src_next;
    logic [ENTRY_W-1:0] m_bypass_reg;

    logic             advance;
    logic             do_update;
    logic             log_write;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] ram_rd;
    logic [ENTRY_W-1:0] entry_out;
    logic [AW-1:0]    rd_addr;
    logic             idx_in_range;
    logic             wr_hit;
    dsd_status_t      dec;

    // Move the held item into the result register when there is room
    assign advance  = s0_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s0_valid_reg || advance;

    dsd_decode u_decode (
        .status_word (s0_sw_reg),
        .status      (dec)
    );

    // Update and log decisions
    assign do_update = advance && enable_reg && !s0_req_reg;
    assign log_write = do_update && (dec.state != last_state_reg);
    assign wr_entry  = {s0_sw_reg, dec.state, last_state_reg, s0_time_reg};

    assign last_state_next = do_update ? dec.state : last_state_reg;
    assign last_flags_next = do_update ? dec.flags : last_flags_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        if (log_write) begin
            wr_ptr_next = (wr_ptr_reg == AW'(LOG_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (fill_reg != CW'(LOG_DEPTH)) begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // Read slot selection, with bypass of this cycle's write
    assign rd_addr      = AW'(s0_idx_reg);
    assign idx_in_range = 32'(s0_idx_reg) < 32'(LOG_DEPTH);
    assign wr_hit       = log_write && (wr_ptr_reg == rd_addr);

    always_comb begin
        if (!idx_in_range) begin
            src_next = ENTRY_ZERO;
        end else if (wr_hit) begin
            src_next = ENTRY_BYPASS;
        end else if (slot_valid_reg[rd_addr]) begin
            src_next = ENTRY_RAM;
        end else begin
            src_next = ENTRY_ZERO;
        end
    end

    dsd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .clk     (aclk),
        .wr_en   (log_write),
        .wr_addr (wr_ptr_reg),
        .wr_data (wr_entry),
        .rd_en   (advance),
        .rd_addr (rd_addr),
        .rd_data (ram_rd)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg     <= 1'b0;
            s0_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            last_state_reg <= ST_UNKNOWN;
            last_flags_reg <= '0;
            wr_ptr_reg     <= '0;
            fill_reg       <= '0;
            slot_valid_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                enable_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                s0_valid_reg <= 1'b1;
            end else if (advance) begin
                s0_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            last_state_reg <= last_state_next;
            last_flags_reg <= last_flags_next;
            wr_ptr_reg     <= wr_ptr_next;
            fill_reg       <= fill_next;
            if (log_write) begin
                slot_valid_reg[wr_ptr_reg] <= 1'b1;
            end
        end
    end

    // Capture input transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s0_req_reg  <= s_tuser;
            s0_sw_reg   <= s_tdata[15:0];
            s0_time_reg <= s_tdata[47:16];
            s0_idx_reg  <= s_tdata[51:48];
        end
    end

    // Load result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_state_reg   <= last_state_next;
            m_flags_reg   <= last_flags_next;
            m_changed_reg <= log_write;
            m_count_reg   <= COUNT_W'(fill_next);
            m_slot_reg    <= SLOT_W'(wr_ptr_next);
            m_src_reg     <= src_next;
            m_bypass_reg  <= wr_entry;
        end
    end

    // Select entry fields
    always_comb begin
        case (m_src_reg)
            ENTRY_RAM:    entry_out = ram_rd;
            ENTRY_BYPASS: entry_out = m_bypass_reg;
            default:      entry_out = '0;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_slot_reg, m_count_reg, entry_out, m_changed_reg,
                       m_flags_reg[2], m_flags_reg[1], m_flags_reg[0], m_state_reg};

endmodule

>>> rtl/dsd_checker.sv
// Port-level checks of the drive status decoder, bound to the top level.
module dsd_checker import dsd_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic                 xfer;
    logic [STATE_W-1:0]   state_code;
    logic                 changed;
    logic [COUNT_W-1:0]   entry_count;
    logic [SLOT_W-1:0]    write_slot;

    assign xfer        = m_tvalid && m_tready;
    assign state_code  = m_tdata[3:0];
    assign changed     = m_tdata[7];
    assign entry_count = m_tdata[68:64];
    assign write_slot  = m_tdata[72:69];

    // Stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result straight after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Back-to-back results without a logged change keep state and log position
    a_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer ##1 (xfer && !changed) |-> (state_code == $past(state_code)) &&
            (write_slot == $past(write_slot)) && (entry_count == $past(entry_count)))
        else $error("state or log moved without a logged change");

    // A logged change means the state differs from the previous result
    a_change: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer ##1 (xfer && changed) |-> (state_code != $past(state_code)) &&
            (write_slot != $past(write_slot)))
        else $error("logged change without a state change");

endmodule

bind drive_status_decode_and_log dsd_checker u_dsd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/tb_drive_status_decode_and_log.sv
// Testbench for the drive status decoder: predicts every result and checks the result stream.
`timescale 1ns / 100ps

import dsd_pkg::*;

// Item kinds carried on s_tuser
localparam bit REQ_UPDATE = 1'b0;
localparam bit REQ_READ   = 1'b1;

// One expected result, field by field
typedef struct {
    logic [STATE_W-1:0] state_code;
    logic               target_reached;
    logic               fault_flag;
    logic               warning_flag;
    logic               changed;
    logic [TIME_W-1:0]  entry_time;
    logic [STATE_W-1:0] entry_from;
    logic [STATE_W-1:0] entry_to;
    logic [SW_W-1:0]    entry_status;
    logic [COUNT_W-1:0] entry_count;
    logic [SLOT_W-1:0]  write_slot;
} drive_report_t;

// Tracks drive state and transition log, and holds the expected results in order
class status_log_tracker;
    bit                 monitor_on;
    logic [STATE_W-1:0] last_state;
    logic [2:0]         last_flags;
    logic [TIME_W-1:0]  log_time [LOG_DEPTH_DEF];
    logic [STATE_W-1:0] log_from [LOG_DEPTH_DEF];
    logic [STATE_W-1:0] log_to [LOG_DEPTH_DEF];
    logic [SW_W-1:0]    log_sw [LOG_DEPTH_DEF];
    int unsigned        wr_ptr;
    int unsigned        fill;
    drive_report_t      expected_reports[$];
    int                 errors;

    function new();
        monitor_on = 1'b0;
        last_state = ST_UNKNOWN;
        last_flags = 3'b000;
        for (int i = 0; i < LOG_DEPTH_DEF; i++) begin
            log_time[i] = '0;
            log_from[i] = '0;
            log_to[i]   = '0;
            log_sw[i]   = '0;
        end
        wr_ptr = 0;
        fill   = 0;
        errors = 0;
    endfunction

    // Decode in the fixed order of checks; first match wins
    function logic [STATE_W-1:0] decode_statusword(logic [SW_W-1:0] sw);
        logic [SW_W-1:0] m;
        m = sw & SW_STATE_MASK;
        if ((m & SW_MASK_SHORT) == SW_PAT_NRDY)   return ST_NOT_READY;
        if ((m & SW_MASK_SHORT) == SW_PAT_SOD)    return ST_SW_ON_DISABLE;
        if ((m & SW_STATE_MASK) == SW_PAT_RDY)    return ST_READY;
        if ((m & SW_STATE_MASK) == SW_PAT_SWON)   return ST_SWITCHED_ON;
        if ((m & SW_STATE_MASK) == SW_PAT_OPEN)   return ST_OP_ENABLED;
        if ((m & SW_STATE_MASK) == SW_PAT_QSTOP)  return ST_QUICK_STOP;
        if ((m & SW_MASK_SHORT) == SW_PAT_FREACT) return ST_FAULT_REACT;
        if ((m & SW_MASK_SHORT) == SW_PAT_FAULT)  return ST_FAULT;
        return ST_UNKNOWN;
    endfunction

    function int pending();
        return expected_reports.size();
    endfunction

    // Advance the state for one accepted input transfer and queue its result
    function void note_item(bit req, logic [SW_W-1:0] sw, logic [TIME_W-1:0] now,
                            logic [IDX_W-1:0] idx);
        drive_report_t      r;
        logic [STATE_W-1:0] cur;
        r.changed = 1'b0;
        if (monitor_on && req == REQ_UPDATE) begin
            cur = decode_statusword(sw);
            last_flags = {sw[SW_BIT_WARNING], sw[SW_BIT_FAULT], sw[SW_BIT_TARGET]};
            if (cur != last_state) begin
                log_time[wr_ptr] = now;
                log_from[wr_ptr] = last_state;
                log_to[wr_ptr]   = cur;
                log_sw[wr_ptr]   = sw;
                wr_ptr = (wr_ptr + 1) % LOG_DEPTH_DEF;
                if (fill < LOG_DEPTH_DEF) fill++;
                r.changed = 1'b1;
            end
            last_state = cur;
        end
        r.state_code     = last_state;
        r.target_reached = last_flags[0];
        r.fault_flag     = last_flags[1];
        r.warning_flag   = last_flags[2];
        r.entry_time     = log_time[idx];
        r.entry_from     = log_from[idx];
        r.entry_to       = log_to[idx];
        r.entry_status   = log_sw[idx];
        r.entry_count    = COUNT_W'(fill);
        r.write_slot     = SLOT_W'(wr_ptr);
        expected_reports.push_back(r);
    endfunction

    // Print one mismatch line (capped) and count it
    task report(string msg);
        if (errors < 40) $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // Compare one result transfer with the oldest expectation
    task check_result(logic [M_DATA_W-1:0] d);
        drive_report_t e;
        if (expected_reports.size() == 0) begin
            report($sformatf("result with nothing expected, data %0h", d));
            return;
        end
        e = expected_reports.pop_front();
        check_field("state_code", d[3:0], e.state_code);
        check_field("target_reached", d[4], e.target_reached);
        check_field("fault_flag", d[5], e.fault_flag);
        check_field("warning_flag", d[6], e.warning_flag);
        check_field("changed", d[7], e.changed);
        check_field("entry_time", d[39:8], e.entry_time);
        check_field("entry_from", d[43:40], e.entry_from);
        check_field("entry_to", d[47:44], e.entry_to);
        check_field("entry_status", d[63:48], e.entry_status);
        check_field("entry_count", d[68:64], e.entry_count);
        check_field("write_slot", d[72:69], e.write_slot);
    endtask
endclass

module tb_drive_status_decode_and_log;

    localparam int CYCLE_LIMIT = 400000;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata     = '0;
    logic                s_tuser     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int                  tx_idle_pct  = 0;
    int                  rx_idle_pct  = 0;
    int                  hold_request = 0;
    int                  hold_left    = 0;
    int unsigned         cycle_count  = 0;
    logic [TIME_W-1:0]   tick_count;
    status_log_tracker   board;

    drive_status_decode_and_log dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Clock: 4 ns period
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("drive_status_decode_and_log: mismatch");
            $finish;
        end
    end

    // Drive m_tready: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check each result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata);
    end

    // Offer one item until it transfers, then note it
    task automatic send_item(bit req, logic [SW_W-1:0] sw, logic [TIME_W-1:0] now,
                             logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0000, idx, now, sw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_item(req, sw, now, idx);
    endtask

    // Hold the input off until every expected result has arrived
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_monitor_enable(bit value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        board.monitor_on = value;
    endtask

    // Mostly well-formed state patterns with random spare bits, some raw words
    task automatic send_random_item();
        bit                req;
        logic [SW_W-1:0]   sw;
        logic [TIME_W-1:0] now;
        int                pick;
        req  = ($urandom_range(99) < 20) ? REQ_READ : REQ_UPDATE;
        sw   = SW_W'($urandom);
        pick = $urandom_range(9);
        case (pick)
            0: sw = (sw & ~SW_MASK_SHORT) | SW_PAT_NRDY;
            1: sw = (sw & ~SW_MASK_SHORT) | SW_PAT_SOD;
            2: sw = (sw & ~SW_STATE_MASK) | SW_PAT_RDY;
            3: sw = (sw & ~SW_STATE_MASK) | SW_PAT_SWON;
            4: sw = (sw & ~SW_STATE_MASK) | SW_PAT_OPEN;
            5: sw = (sw & ~SW_STATE_MASK) | SW_PAT_QSTOP;
            6: sw = (sw & ~SW_MASK_SHORT) | SW_PAT_FREACT;
            7: sw = (sw & ~SW_MASK_SHORT) | SW_PAT_FAULT;
            default: ;
        endcase
        tick_count += $urandom_range(1, 40);
        now = ($urandom_range(3) == 0) ? TIME_W'($urandom) : tick_count;
        send_item(req, sw, now, IDX_W'($urandom_range(15)));
    endtask

    initial begin
        board = new();
        tick_count = $urandom;
        tx_idle_pct = 18;
        rx_idle_pct = 53;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Monitor still disabled from reset: nothing may change
        send_item(REQ_UPDATE, SW_PAT_OPEN, 32'h0000_1234, 4'd0);
        send_item(REQ_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'd0);

        // Walk every state, logging each transition
        write_monitor_enable(1'b1);
        send_item(REQ_UPDATE, SW_PAT_NRDY, 32'h0000_0000, 4'd0);
        send_item(REQ_UPDATE, SW_PAT_SOD, 32'hFFFF_FFFF, 4'd1);
        send_item(REQ_UPDATE, SW_PAT_RDY, 32'h0000_0010, 4'd2);
        send_item(REQ_UPDATE, SW_PAT_SWON, 32'h0000_0020, 4'd3);
        send_item(REQ_UPDATE, SW_PAT_OPEN, 32'h0000_0030, 4'd4);
        // same state again, target and warning bits set: no log entry
        send_item(REQ_UPDATE, 16'h04A7, 32'h0000_0040, 4'd4);
        send_item(REQ_UPDATE, SW_PAT_QSTOP, 32'h0000_0050, 4'd5);
        send_item(REQ_UPDATE, 16'h048F, 32'h8000_0000, 4'd6);
        send_item(REQ_UPDATE, SW_PAT_FAULT, 32'h0000_0070, 4'd7);
        // unmatched patterns decode to unknown
        send_item(REQ_UPDATE, 16'hFFFF, 32'h0000_0080, 4'd8);
        send_item(REQ_UPDATE, 16'h0001, 32'h0000_0090, 4'd9);
        // reads: the highest slot (never written), the first slot, and the slot just written
        send_item(REQ_READ, 16'hFFFF, 32'hFFFF_FFFF, 4'd15);
        send_item(REQ_READ, 16'h0000, 32'h0000_0000, 4'd0);
        send_item(REQ_UPDATE, 16'hFB90, 32'hFFFF_FFFF, 4'd15);
        send_item(REQ_READ, 16'h0000, 32'h0000_0000, 4'd9);

        // Random phases across the three idling modes, enabled then disabled
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 18 : (mode == 1) ? 53 : 0;
            rx_idle_pct = (mode == 0) ? 53 : (mode == 1) ? 18 : 0;
            write_monitor_enable(1'b1);
            hold_request = 150;
            for (int i = 0; i < 270; i++) begin
                if (i == 135) drain_results();
                send_random_item();
            end
            write_monitor_enable(1'b0);
            for (int i = 0; i < 30; i++) send_random_item();
        end

        drain_results();
        repeat (6) @(posedge aclk);
        if (board.errors == 0) begin
            $display("drive_status_decode_and_log: match");
        end else begin
            $display("drive_status_decode_and_log: mismatch");
        end
        $finish;
    end

endmodule
